/* rtl/core/tfcd_pkg.sv */
// Shared constants, types and helpers for the tile frame change detector.
// No dependencies; imported by every module of the block.
package tfcd_pkg;

	// Geometry limits
	localparam int BLOCK_SIZE          = 32;
	localparam int MAX_WIDTH           = 1024;
	localparam int MAX_HEIGHT          = 1024;
	localparam int MAX_BYTES_PER_PIXEL = 4;

	// Derived sizes (block size and store size are powers of two)
	localparam int BLK_SH      = $clog2(BLOCK_SIZE);
	localparam int FLAG_COUNT  = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int FLAG_AW     = $clog2(FLAG_COUNT);
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_BYTES_PER_PIXEL;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	// Field widths
	localparam int BYTE_W  = 8;
	localparam int COL_W   = 12;   // byte position within a row
	localparam int ROW_W   = 10;   // pixel row within the region
	localparam int POS_W   = 10;   // left / top output columns
	localparam int EDGE_W  = 11;   // right / bottom output edges
	localparam int WID_W   = 11;   // frame and region width / height
	localparam int BPP_W   = 3;
	localparam int CFG_W   = 11;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_W   = 48;   // 42 bits of fields padded to whole bytes

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH     = 3'd0,
		REG_BYTES_PER_PIXEL = 3'd1,
		REG_REGION_X        = 3'd2,
		REG_REGION_Y        = 3'd3,
		REG_REGION_WIDTH    = 3'd4,
		REG_REGION_HEIGHT   = 3'd5
	} cfg_reg_t;

	// Frame store write and read request
	typedef struct packed {
		logic                wr_en;
		logic [STORE_AW-1:0] wr_addr;
		logic [BYTE_W-1:0]   wr_data;
		logic                rd_en;
		logic [STORE_AW-1:0] rd_addr;
	} store_req_t;

	// floor(x / 3) for 12-bit x: multiply by reciprocal 2731 / 2^13
	function automatic logic [COL_W-1:0] div3(input logic [COL_W-1:0] x);
		logic [COL_W+12:0] p;
		p = (COL_W+13)'(x) * (COL_W+13)'(12'd2731);
		return p[COL_W+12:13];
	endfunction

	// Out-of-range pixel sizes act as the nearest legal value
	function automatic logic [BPP_W-1:0] clamp_bpp(input logic [BPP_W-1:0] v);
		if (v == '0)
			return BPP_W'(1);
		else if (v > BPP_W'(MAX_BYTES_PER_PIXEL))
			return BPP_W'(MAX_BYTES_PER_PIXEL);
		else
			return v;
	endfunction

	function automatic logic [WID_W-1:0] clamp_dim(input logic [WID_W-1:0] v,
		input logic [WID_W-1:0] hi);
		if (v == '0)
			return WID_W'(1);
		else if (v > hi)
			return hi;
		else
			return v;
	endfunction

endpackage

/* rtl/core/tfcd_store.sv */
// Frame store: single write port, single registered read port, no reset.
// Depends on tfcd_pkg for the store size and the access struct.
module tfcd_store (
	input  logic                     clk,
	input  tfcd_pkg::store_req_t     req,
	output logic [tfcd_pkg::BYTE_W-1:0] rd_data
);
	import tfcd_pkg::*;

	logic [BYTE_W-1:0] mem [STORE_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	// Read returns the old contents when both ports hit one address
	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en)
			rd_data_q <= mem[req.rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/core/tile_frame_change_detector_top.sv */
// Top level of the tile frame change detector: counters, address pipeline,
// block flags and result register. Depends on tfcd_pkg and tfcd_store.
//
// Usage
//   s_axis carries the captured region one byte per beat in raster order;
//   tuser marks a prime beat, loaded into the frame store unchecked. m_axis
//   carries one beat per dirty block: its rectangle, clipped to the region.
//   Registers are written through cfg_we / cfg_index / cfg_data while the
//   block is idle and apply to the next byte.
// Timing
//   One byte is taken every clock while the pipeline is not held. A byte
//   passes three stages (counters, row multiply, store address and read);
//   the result register takes its report from the last stage onto m_axis.
//   The rate is set by the single store port pair: one read and one write
//   per clock, with a bypass for a byte written in the same cycle as its reread.
// Reset
//   arst_n clears the position counters, the block flags, the pipeline and
//   the result register and loads the register reset values. The store
//   keeps no reset; prime a frame before comparing against it.
// Back-pressure
//   s_axis_tready drops only when a report waits on m_axis and the byte in
//   the last stage would give another one; the pipeline then holds.
module tile_frame_change_detector_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,   // [7:0] pixel_byte
	input  logic [0:0]                      s_axis_tuser,   // [0] prime
	// result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [9:0] dirty_left, [19:10] dirty_top, [30:20] dirty_right,
	// [41:31] dirty_bottom, [47:42] zero
	output logic [tfcd_pkg::OUT_W-1:0]      m_axis_tdata,
	// configuration
	input  logic                            cfg_we,
	input  logic [tfcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tfcd_pkg::CFG_W-1:0]      cfg_data
);
	import tfcd_pkg::*;

	// Configuration registers
	logic [WID_W-1:0] frame_width_q;
	logic [BPP_W-1:0] bpp_q;
	logic [POS_W-1:0] region_x_q;
	logic [POS_W-1:0] region_y_q;
	logic [WID_W-1:0] region_width_q;
	logic [WID_W-1:0] region_height_q;

	// Position counters
	logic [COL_W-1:0] byte_col_q;
	logic [ROW_W-1:0] pixel_row_q;

	// Block flags
	logic [FLAG_COUNT-1:0] flags_q;

	// Result register
	logic             out_valid_q;
	logic [POS_W-1:0] out_left_q;
	logic [POS_W-1:0] out_top_q;
	logic [EDGE_W-1:0] out_right_q;
	logic [EDGE_W-1:0] out_bottom_q;

	// Clamped configuration
	logic [BPP_W-1:0] bpp_c;
	logic [WID_W-1:0] rw_c;
	logic [WID_W-1:0] rh_c;

	// Accept stage
	logic              adv;
	logic              s_fire;
	logic [COL_W:0]    row_bytes;
	logic [COL_W:0]    col_inc;
	logic              row_end_c;
	logic              last_row_c;

	// Stage 1
	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              prime_s1;
	logic [COL_W-1:0]  bc_s1;
	logic [ROW_W-1:0]  pr_s1;
	logic              row_end_s1;
	logic              last_row_s1;
	logic [COL_W-1:0]  col_s1c;
	logic [COL_W:0]    bc_inc_s1;
	logic [COL_W-BLK_SH:0] blk_cnt_s1;
	logic              blk_div_s1;
	logic              col_end_s1c;
	logic [WID_W-1:0]  row_sum_s1;
	logic [STORE_AW-1:0] rowp_s1c;

	// Stage 2
	logic              v_s2;
	logic [BYTE_W-1:0] byte_s2;
	logic              prime_s2;
	logic [COL_W-1:0]  bc_s2;
	logic [COL_W-1:0]  col_s2;
	logic [ROW_W-1:0]  pr_s2;
	logic              col_end_s2;
	logic              row_end_blk_s2;
	logic [STORE_AW-1:0] rowp_s2;
	logic [STORE_AW-1:0] addr_s2c;
	logic [COL_W:0]    left_full;
	logic [COL_W:0]    left_span;
	logic [COL_W:0]    right_lim;
	logic [EDGE_W:0]   top_full;
	logic [EDGE_W:0]   top_span;
	logic [EDGE_W:0]   bot_lim;
	logic [EDGE_W-1:0] right_s2c;
	logic [EDGE_W-1:0] bottom_s2c;

	// Stage 3
	logic              v_s3;
	logic [BYTE_W-1:0] byte_s3;
	logic              prime_s3;
	logic [STORE_AW-1:0] addr_s3;
	logic [FLAG_AW-1:0] fidx_s3;
	logic              blk_end_s3;
	logic [POS_W-1:0]  left_s3;
	logic [POS_W-1:0]  top_s3;
	logic [EDGE_W-1:0] right_s3;
	logic [EDGE_W-1:0] bottom_s3;
	logic              fwd_s3;
	logic [BYTE_W-1:0] fwd_byte_s3;
	logic [BYTE_W-1:0] rd_data;
	logic [BYTE_W-1:0] old_byte;
	logic              flag_now;
	logic              emit_want;
	logic              emit;

	store_req_t        store_req;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= WID_W'(MAX_WIDTH);
			bpp_q           <= BPP_W'(MAX_BYTES_PER_PIXEL);
			region_x_q      <= '0;
			region_y_q      <= '0;
			region_width_q  <= WID_W'(MAX_WIDTH);
			region_height_q <= WID_W'(MAX_HEIGHT);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:     frame_width_q   <= cfg_data[WID_W-1:0];
				REG_BYTES_PER_PIXEL: bpp_q           <= cfg_data[BPP_W-1:0];
				REG_REGION_X:        region_x_q      <= cfg_data[POS_W-1:0];
				REG_REGION_Y:        region_y_q      <= cfg_data[POS_W-1:0];
				REG_REGION_WIDTH:    region_width_q  <= cfg_data[WID_W-1:0];
				REG_REGION_HEIGHT:   region_height_q <= cfg_data[WID_W-1:0];
				default: ;
			endcase
		end
	end

	assign bpp_c = clamp_bpp(bpp_q);
	assign rw_c  = clamp_dim(region_width_q, WID_W'(MAX_WIDTH));
	assign rh_c  = clamp_dim(region_height_q, WID_W'(MAX_HEIGHT));

	// Handshake: the whole pipeline holds only for a blocked report
	assign adv           = !(out_valid_q && !m_axis_tready && emit_want);
	assign s_axis_tready = adv;
	assign s_fire        = s_axis_tvalid && adv;

	// Row and region end from the live counters
	assign row_bytes  = (COL_W+1)'(rw_c) * (COL_W+1)'(bpp_c);
	assign col_inc    = (COL_W+1)'(byte_col_q) + (COL_W+1)'(1);
	assign row_end_c  = col_inc >= row_bytes;
	assign last_row_c = (WID_W'(pixel_row_q) + WID_W'(1)) >= rh_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_col_q  <= '0;
			pixel_row_q <= '0;
		end else if (s_fire) begin
			if (row_end_c) begin
				byte_col_q  <= '0;
				pixel_row_q <= last_row_c ? '0 : pixel_row_q + ROW_W'(1);
			end else begin
				byte_col_q  <= col_inc[COL_W-1:0];
			end
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1 load
	always_ff @(posedge clk) begin
		if (adv) begin
			byte_s1     <= s_axis_tdata;
			prime_s1    <= s_axis_tuser[0];
			bc_s1       <= byte_col_q;
			pr_s1       <= pixel_row_q;
			row_end_s1  <= row_end_c;
			last_row_s1 <= last_row_c;
		end
	end

	// Stage 1: pixel column, block column end and store row offset
	always_comb begin
		unique case (bpp_c)
			BPP_W'(1): col_s1c = bc_s1;
			BPP_W'(2): col_s1c = {1'b0, bc_s1[COL_W-1:1]};
			BPP_W'(3): col_s1c = div3(bc_s1);
			default:   col_s1c = {2'b00, bc_s1[COL_W-1:2]};
		endcase
	end

	assign bc_inc_s1  = (COL_W+1)'(bc_s1) + (COL_W+1)'(1);
	assign blk_cnt_s1 = bc_inc_s1[COL_W:BLK_SH];

	// Block column end: next byte position a multiple of BLOCK_SIZE pixels
	always_comb begin
		unique case (bpp_c)
			BPP_W'(1): blk_div_s1 = 1'b1;
			BPP_W'(2): blk_div_s1 = !blk_cnt_s1[0];
			BPP_W'(3): blk_div_s1 = (div3(COL_W'(blk_cnt_s1)) * COL_W'(3))
				== COL_W'(blk_cnt_s1);
			default:   blk_div_s1 = blk_cnt_s1[1:0] == 2'b00;
		endcase
	end

	assign col_end_s1c = row_end_s1 ||
		((bc_inc_s1[BLK_SH-1:0] == '0) && blk_div_s1);
	assign row_sum_s1  = WID_W'(region_y_q) + WID_W'(pr_s1);
	assign rowp_s1c    = STORE_AW'(row_sum_s1) * STORE_AW'(frame_width_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_s2        <= byte_s1;
			prime_s2       <= prime_s1;
			bc_s2          <= bc_s1;
			col_s2         <= col_s1c;
			pr_s2          <= pr_s1;
			col_end_s2     <= col_end_s1c;
			row_end_blk_s2 <= last_row_s1 || (pr_s1[BLK_SH-1:0] == '1);
			rowp_s2        <= rowp_s1c;
		end
	end

	// Stage 2: byte address and clipped rectangle
	assign addr_s2c = (rowp_s2 + STORE_AW'(region_x_q)) * STORE_AW'(bpp_c)
		+ STORE_AW'(bc_s2);

	assign left_full = (COL_W+1)'(region_x_q)
		+ (COL_W+1)'({col_s2[COL_W-1:BLK_SH], BLK_SH'(0)});
	assign left_span = left_full + (COL_W+1)'(BLOCK_SIZE);
	assign right_lim = (COL_W+1)'(region_x_q) + (COL_W+1)'(rw_c);
	assign right_s2c = (left_span > right_lim) ? right_lim[EDGE_W-1:0]
		: left_span[EDGE_W-1:0];

	assign top_full   = (EDGE_W+1)'(region_y_q)
		+ (EDGE_W+1)'({pr_s2[ROW_W-1:BLK_SH], BLK_SH'(0)});
	assign top_span   = top_full + (EDGE_W+1)'(BLOCK_SIZE);
	assign bot_lim    = (EDGE_W+1)'(region_y_q) + (EDGE_W+1)'(rh_c);
	assign bottom_s2c = (top_span > bot_lim) ? bot_lim[EDGE_W-1:0]
		: top_span[EDGE_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_s3     <= byte_s2;
			prime_s3    <= prime_s2;
			addr_s3     <= addr_s2c;
			fidx_s3     <= col_s2[BLK_SH +: FLAG_AW];
			blk_end_s3  <= col_end_s2 && row_end_blk_s2;
			left_s3     <= left_full[POS_W-1:0];
			top_s3      <= top_full[POS_W-1:0];
			right_s3    <= right_s2c;
			bottom_s3   <= bottom_s2c;
			// byte written this edge is the one the new stage 3 must see
			fwd_s3      <= v_s3 && (addr_s3 == addr_s2c);
			fwd_byte_s3 <= byte_s3;
		end
	end

	// Store: read in stage 2, write back in stage 3
	always_comb begin
		store_req.wr_en   = adv && v_s3;
		store_req.wr_addr = addr_s3;
		store_req.wr_data = byte_s3;
		store_req.rd_en   = adv && v_s2;
		store_req.rd_addr = addr_s2c;
	end

	tfcd_store u_store (
		.clk     (clk),
		.req     (store_req),
		.rd_data (rd_data)
	);

	// Stage 3: compare, flag update and report decision
	assign old_byte  = fwd_s3 ? fwd_byte_s3 : rd_data;
	assign flag_now  = flags_q[fidx_s3] || (!prime_s3 && (old_byte != byte_s3));
	assign emit_want = v_s3 && blk_end_s3 && !prime_s3 && flag_now;
	assign emit      = emit_want && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (adv && v_s3) begin
			flags_q[fidx_s3] <= blk_end_s3 ? 1'b0 : flag_now;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_left_q   <= left_s3;
			out_top_q    <= top_s3;
			out_right_q  <= right_s3;
			out_bottom_q <= bottom_s3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_W-2*POS_W-2*EDGE_W)'(0), out_bottom_q, out_right_q,
		out_top_q, out_left_q};

endmodule

/* rtl/core/tfcd_checker.sv */
// Port-level checks for the tile frame change detector, bound to the top.
// Depends on tfcd_pkg for the result width.
module tfcd_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [tfcd_pkg::OUT_W-1:0]  m_axis_tdata
);
	import tfcd_pkg::*;

	// A waiting report is not withdrawn
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	// A waiting report does not change
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// Input is only held back by a blocked report
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input held without a blocked report");

	// Padding above the rectangle fields stays zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_W-1:2*POS_W+2*EDGE_W] == '0))
		else $error("result padding not zero");

endmodule

bind tile_frame_change_detector_top tfcd_checker u_tfcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

/* dv/tile_frame_change_detector_top_tb.sv */
// Self-checking testbench for tile_frame_change_detector_top: a directed table, then random
// capture phases, checked against a behavioural model of the dirty-block logic or typed expected results.
// Depends on tfcd_pkg and the RTL of the block; stands alone otherwise.
module tile_frame_change_detector_top_tb;
	import tfcd_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int DRAIN_CYCLES = 8;      // pipeline is three stages deep
	localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
	localparam int RANDOM_BEATS = 520;

	// One dirty rectangle as packed on m_axis_tdata (left in the lowest bits)
	typedef struct packed {
		logic [EDGE_W-1:0] bottom;
		logic [EDGE_W-1:0] right;
		logic [POS_W-1:0]  top;
		logic [POS_W-1:0]  left;
	} dirty_rect_t;

	typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

	// Directed stimulus row; typed rows carry their own expected result
	typedef struct {
		row_kind_t   kind;
		cfg_reg_t    reg_idx;
		logic [10:0] value;
		logic [7:0]  pix;
		logic        prime;
		bit          typed;
		bit          exp_has;
		dirty_rect_t exp_rect;
	} stim_row_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata  = '0;
	logic [0:0]           s_axis_tuser  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_W-1:0]     m_axis_tdata;
	logic                 cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [CFG_W-1:0]     cfg_data      = '0;

	// Model state: frame copy, block flags, position and registers
	logic [7:0]        frame_copy [int unsigned];
	bit [FLAG_COUNT-1:0] block_dirty;
	logic [COL_W-1:0]  byte_col;
	logic [ROW_W-1:0]  pix_row;
	logic [10:0]       frame_w;
	logic [2:0]        bpp_reg;
	logic [9:0]        org_x;
	logic [9:0]        org_y;
	logic [10:0]       reg_w;
	logic [10:0]       reg_h;

	dirty_rect_t pending_dirty [$];
	stim_row_t   directed_rows [$];
	int          err_count    = 0;
	int          beats_random = 0;
	bit          tx_burst     = 1'b0;
	bit          rx_burst     = 1'b0;
	bit          stall_req    = 1'b0;

	tile_frame_change_detector_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Clock
	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Run limit
	initial begin
		#(2 * HALF_PERIOD * 400000);
		$display("tile_frame_change_detector_top test failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint unsigned got,
		input longint unsigned want);
		err_count++;
		if (err_count <= 50)
			$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
	endtask

	function automatic int unsigned eff_bpp();
		if (bpp_reg == 3'd0)
			return 1;
		else if (bpp_reg > 3'(MAX_BYTES_PER_PIXEL))
			return MAX_BYTES_PER_PIXEL;
		return bpp_reg;
	endfunction

	function automatic int unsigned eff_dim(input logic [10:0] v, input int unsigned hi);
		if (v == 11'd0)
			return 1;
		else if (v > hi)
			return hi;
		return v;
	endfunction

	// Store byte address of the current position, wrapped to the store
	function automatic int unsigned frame_addr();
		longint unsigned a;
		longint unsigned bpp;
		bpp = 64'(eff_bpp());
		a = (64'(org_y) + 64'(pix_row)) * 64'(frame_w) * bpp + 64'(org_x) * bpp
			+ 64'(byte_col);
		return int'(a % 64'(STORE_DEPTH));
	endfunction

	function automatic void apply_reg(input cfg_reg_t idx, input logic [10:0] val);
		case (idx)
			REG_FRAME_WIDTH:     frame_w = val;
			REG_BYTES_PER_PIXEL: bpp_reg = val[2:0];
			REG_REGION_X:        org_x   = val[9:0];
			REG_REGION_Y:        org_y   = val[9:0];
			REG_REGION_WIDTH:    reg_w   = val;
			REG_REGION_HEIGHT:   reg_h   = val;
			default: ;
		endcase
	endfunction

	// Compare one byte with the frame copy and work out any dirty block it closes
	task automatic predict_dirty(input logic [7:0] pix, input logic prime,
		output bit has, output dirty_rect_t rect);
		int unsigned bpp, rw, rh, row_bytes, col, blk, fi;
		int unsigned left, top, right, bottom, addr;
		bit row_end, last_row, col_end, row_blk_end;
		logic [7:0] held;
		bpp       = eff_bpp();
		rw        = eff_dim(reg_w, MAX_WIDTH);
		rh        = eff_dim(reg_h, MAX_HEIGHT);
		row_bytes = rw * bpp;
		col       = int'(byte_col) / bpp;
		blk       = col / BLOCK_SIZE;
		fi        = blk % FLAG_COUNT;
		row_end   = int'(byte_col) + 1 >= row_bytes;
		last_row  = int'(pix_row) + 1 >= rh;
		col_end   = row_end || ((int'(byte_col) + 1) % (BLOCK_SIZE * bpp)) == 0;
		row_blk_end = last_row || (int'(pix_row) % BLOCK_SIZE) == BLOCK_SIZE - 1;
		addr      = frame_addr();
		held      = frame_copy.exists(addr) ? frame_copy[addr] : 8'h00;
		has       = 1'b0;
		rect      = '0;
		if (!prime && held != pix)
			block_dirty[fi] = 1'b1;
		frame_copy[addr] = pix;
		// block closed: report if anything changed, clip to the region
		if (col_end && row_blk_end) begin
			if (!prime && block_dirty[fi]) begin
				left   = org_x + blk * BLOCK_SIZE;
				top    = org_y + (int'(pix_row) / BLOCK_SIZE) * BLOCK_SIZE;
				right  = left + BLOCK_SIZE;
				bottom = top + BLOCK_SIZE;
				if (right > org_x + rw)
					right = org_x + rw;
				if (bottom > org_y + rh)
					bottom = org_y + rh;
				rect.left   = POS_W'(left);
				rect.top    = POS_W'(top);
				rect.right  = EDGE_W'(right);
				rect.bottom = EDGE_W'(bottom);
				has = 1'b1;
			end
			block_dirty[fi] = 1'b0;
		end
		// advance the raster position
		if (row_end) begin
			byte_col = '0;
			pix_row  = last_row ? '0 : pix_row + 1'b1;
		end else begin
			byte_col = byte_col + 1'b1;
		end
	endtask

	// Offer one byte, wait for the beat, then queue what it should report
	task automatic send_beat(input logic [7:0] pix, input logic prime, input bit typed,
		input bit t_has, input dirty_rect_t t_rect);
		int gap;
		bit has;
		dirty_rect_t rect;
		gap = tx_burst ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		s_axis_tuser  <= prime;
		do @(posedge clk); while (!s_axis_tready);
		predict_dirty(pix, prime, has, rect);
		if (typed) begin
			has  = t_has;
			rect = t_rect;
		end
		if (has)
			pending_dirty.push_back(rect);
	endtask

	// Let every expected report arrive and the pipeline empty
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_dirty.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after the last write
	task automatic cfg_write(input cfg_reg_t idx, input logic [10:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		apply_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic logic [10:0] draw_reg_value(input cfg_reg_t idx);
		int unsigned roll;
		logic [10:0] v;
		roll = $urandom_range(0, 99);
		case (idx)
			REG_FRAME_WIDTH: begin
				if (roll < 10)      v = 11'd0;
				else if (roll < 20) v = 11'd2047;
				else if (roll < 30) v = 11'd1;
				else if (roll < 45) v = 11'd1024;
				else                v = 11'($urandom_range(1, 1024));
			end
			REG_BYTES_PER_PIXEL: begin
				// upper data bits are junk the block must drop
				v = 11'($urandom_range(0, 255) << 3);
				if (roll < 15) v[2:0] = 3'($urandom_range(0, 7));
				else           v[2:0] = 3'($urandom_range(1, 4));
			end
			REG_REGION_X, REG_REGION_Y: begin
				if (roll < 20)      v = 11'd1023;
				else if (roll < 60) v = 11'($urandom_range(0, 40));
				else                v = 11'($urandom_range(0, 1023));
				v[10] = 1'($urandom_range(0, 1));
			end
			REG_REGION_WIDTH: begin
				if (roll < 55)      v = 11'($urandom_range(1, 6));
				else if (roll < 70) v = 11'($urandom_range(28, 40));
				else if (roll < 80) v = 11'd0;
				else if (roll < 90) v = 11'($urandom_range(1025, 2047));
				else                v = 11'd1024;
			end
			default: begin
				if (roll < 60)      v = 11'($urandom_range(1, 3));
				else if (roll < 75) v = 11'($urandom_range(31, 34));
				else if (roll < 85) v = 11'd0;
				else if (roll < 93) v = 11'($urandom_range(1025, 2047));
				else                v = 11'd1024;
			end
		endcase
		return v;
	endfunction

	// One random phase of capture: primes wherever the copy has no byte yet
	task automatic run_phase(input int n, input int chg_pct, input int prime_pct);
		int unsigned addr;
		logic [7:0] pix;
		logic prime;
		for (int i = 0; i < n; i++) begin
			addr = frame_addr();
			if (!frame_copy.exists(addr))
				prime = 1'b1;
			else
				prime = $urandom_range(0, 99) < prime_pct;
			if (prime || $urandom_range(0, 99) < chg_pct)
				pix = 8'($urandom_range(0, 255));
			else
				pix = frame_copy[addr];
			send_beat(pix, prime, 1'b0, 1'b0, '0);
			beats_random++;
		end
	endtask

	function automatic void add_cfg(input cfg_reg_t idx, input logic [10:0] val);
		stim_row_t r;
		r = '{kind: ROW_CFG, reg_idx: idx, value: val, pix: '0, prime: 1'b0,
			typed: 1'b0, exp_has: 1'b0, exp_rect: '0};
		directed_rows.push_back(r);
	endfunction

	function automatic void add_beat(input logic [7:0] pix, input logic prime,
		input bit typed, input bit has, input dirty_rect_t rect);
		stim_row_t r;
		r = '{kind: ROW_BEAT, reg_idx: REG_FRAME_WIDTH, value: '0, pix: pix, prime: prime,
			typed: typed, exp_has: has, exp_rect: rect};
		directed_rows.push_back(r);
	endfunction

	// Result checker
	always @(posedge clk) begin
		dirty_rect_t got;
		dirty_rect_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = dirty_rect_t'(m_axis_tdata[41:0]);
			if (m_axis_tdata[OUT_W-1:42] != '0)
				report_mismatch("padding bits", m_axis_tdata[OUT_W-1:42], 0);
			if (pending_dirty.size() == 0) begin
				report_mismatch("dirty beat with none expected, left", got.left, 0);
			end else begin
				want = pending_dirty.pop_front();
				if (got.left != want.left)
					report_mismatch("dirty_left", got.left, want.left);
				if (got.top != want.top)
					report_mismatch("dirty_top", got.top, want.top);
				if (got.right != want.right)
					report_mismatch("dirty_right", got.right, want.right);
				if (got.bottom != want.bottom)
					report_mismatch("dirty_bottom", got.bottom, want.bottom);
			end
		end
	end

	// Receiver: random stalls, bursts, and one long hold-off on request
	initial begin
		int gap;
		int rx_count;
		rx_count = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (stall_req) begin
				stall_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = rx_burst ? 0 : $urandom_range(0, 14);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			rx_count++;
			if (rx_count % 20 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
		end
	end

	// Stimulus
	initial begin
		bit in_cfg;
		bit wrote;
		int phase_no;
		int n;
		int chg_pct;
		int prime_pct;
		int unsigned fb;
		stim_row_t r;
		dirty_rect_t rect;

		// reset values of the model
		frame_copy.delete();
		block_dirty = '0;
		byte_col    = '0;
		pix_row     = '0;
		frame_w     = 11'd1024;
		bpp_reg     = 3'd4;
		org_x       = '0;
		org_y       = '0;
		reg_w       = 11'd1024;
		reg_h       = 11'd1024;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two-pixel region at the origin, one byte per pixel
		add_cfg(REG_FRAME_WIDTH, 11'd1024);
		add_cfg(REG_BYTES_PER_PIXEL, 11'd1);
		add_cfg(REG_REGION_X, 11'd0);
		add_cfg(REG_REGION_Y, 11'd0);
		add_cfg(REG_REGION_WIDTH, 11'd2);
		add_cfg(REG_REGION_HEIGHT, 11'd1);
		add_beat(8'h00, 1'b1, 1'b1, 1'b0, '0);
		add_beat(8'hFF, 1'b1, 1'b1, 1'b0, '0);    // prime closing a block: silent
		add_beat(8'h00, 1'b0, 1'b1, 1'b0, '0);
		rect = '{bottom: 11'd1, right: 11'd2, top: 10'd0, left: 10'd0};
		add_beat(8'h7F, 1'b0, 1'b1, 1'b1, rect);  // changed byte closes the block
		add_beat(8'h00, 1'b0, 1'b1, 1'b0, '0);
		add_beat(8'h7F, 1'b0, 1'b1, 1'b0, '0);
		add_beat(8'h55, 1'b0, 1'b1, 1'b0, '0);
		add_beat(8'h7F, 1'b1, 1'b1, 1'b0, '0);    // prime clears the pending flag
		add_beat(8'h55, 1'b0, 1'b1, 1'b0, '0);
		add_beat(8'h7F, 1'b0, 1'b1, 1'b0, '0);
		// Region hanging off the frame corner: address wraps, edges clip
		add_cfg(REG_BYTES_PER_PIXEL, 11'd4);
		add_cfg(REG_REGION_X, 11'd1023);
		add_cfg(REG_REGION_Y, 11'd1023);
		add_cfg(REG_REGION_WIDTH, 11'd2);
		for (int i = 0; i < 8; i++)
			add_beat(8'hA0 + 8'(i), 1'b1, 1'b0, 1'b0, '0);
		for (int i = 0; i < 7; i++)
			add_beat((i == 6) ? 8'h00 : 8'hA0 + 8'(i), 1'b0, 1'b0, 1'b0, '0);
		rect = '{bottom: 11'd1024, right: 11'd1025, top: 10'd1023, left: 10'd1023};
		add_beat(8'hA7, 1'b0, 1'b1, 1'b1, rect);

		in_cfg = 1'b0;
		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			if (r.kind == ROW_CFG) begin
				if (!in_cfg) begin
					wait_drained();
					in_cfg = 1'b1;
				end
				cfg_write(r.reg_idx, r.value);
			end else begin
				if (in_cfg) begin
					cfg_we <= 1'b0;
					in_cfg = 1'b0;
				end
				send_beat(r.pix, r.prime, r.typed, r.exp_has, r.exp_rect);
			end
		end

		// Random phases until enough beats have gone through
		phase_no = 0;
		while (beats_random < RANDOM_BEATS) begin
			wait_drained();
			wrote = 1'b0;
			if (phase_no == 2) begin
				// one-pixel region: every byte closes a block, so reports pile up
				cfg_write(REG_BYTES_PER_PIXEL, 11'd1);
				cfg_write(REG_REGION_WIDTH, 11'd1);
				cfg_write(REG_REGION_HEIGHT, 11'd1);
				wrote = 1'b1;
			end else begin
				for (int k = 0; k <= int'(REG_REGION_HEIGHT); k++) begin
					if ($urandom_range(0, 99) < 60) begin
						cfg_write(cfg_reg_t'(k), draw_reg_value(cfg_reg_t'(k)));
						wrote = 1'b1;
					end
				end
			end
			if (wrote)
				cfg_we <= 1'b0;

			case ($urandom_range(0, 3))
				0:       chg_pct = 0;
				1:       chg_pct = 3;
				2:       chg_pct = 20;
				default: chg_pct = 60;
			endcase
			case ($urandom_range(0, 2))
				0:       prime_pct = 0;
				1:       prime_pct = 5;
				default: prime_pct = 15;
			endcase
			tx_burst = ($urandom_range(0, 3) == 0);
			fb = eff_dim(reg_w, MAX_WIDTH) * eff_bpp() * eff_dim(reg_h, MAX_HEIGHT);
			if (fb <= 48)
				n = int'(fb) * $urandom_range(1, 4) + $urandom_range(0, 3);
			else
				n = $urandom_range(8, 64);
			if (phase_no == 2) begin
				n         = 80;
				chg_pct   = 60;
				prime_pct = 0;
				tx_burst  = 1'b1;
				stall_req = 1'b1;
			end
			// last phase stops at the beat budget
			if (n > RANDOM_BEATS - beats_random)
				n = RANDOM_BEATS - beats_random;
			run_phase(n, chg_pct, prime_pct);
			phase_no++;
		end

		wait_drained();
		if (err_count == 0)
			$display("tile_frame_change_detector_top test passed");
		else
			$display("tile_frame_change_detector_top test failed");
		$finish;
	end

endmodule
